// ===== hdl/fwwg_pkg.sv =====
// shared types and constants of the flash write wear guard
package fwwg_pkg;

    // field and register widths
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 18;
    localparam int HEAT_W  = 10;
    localparam int TIMER_W = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // slack that the end check allows past window_end
    localparam int END_SLACK = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAR_THRESHOLD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_SECONDS = 2'd3;

    // register reset values
    localparam logic [ADDR_W-1:0]  RST_WINDOW_START     = 32'd0;
    localparam logic [ADDR_W-1:0]  RST_WINDOW_END       = 32'd130047;
    localparam logic [HEAT_W-1:0]  RST_WEAR_THRESHOLD   = 10'd1000;
    localparam logic [TIMER_W-1:0] RST_THROTTLE_SECONDS = 17'd86400;

    // input item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_SEC_FAIL  = 3'd1,
        ST_WINDOW    = 3'd2,
        ST_THROTTLED = 3'd3,
        ST_THRESHOLD = 3'd4
    } t_status;

endpackage

// ===== hdl/flash_write_wear_guard_top.sv =====
// flash write wear guard: admission gate with per-page heat counters in memory
//
// Input channel (i_s_*): one item is a write request (tuser = 0) or a one-second
// tick (tuser = 1). A tick gives no result and counts the
// throttle timer down. A write request gives exactly one result item on the
// output channel (o_m_*): status and a granted flag.
// A write request passes the check state, which sends it straight to the output
// register when it fails the security, window or throttle check; then the page
// span state, which does the same when its last page lies beyond the page store;
// then a memory read and a write back per page walked, then the output register.
// A threshold hit during the walk ends it with a clearing pass of the heat memory
// before the output register. The page count of the request sets the time;
// PAGE_BYTES must be a power of two, which the block itself does not enforce.
// Only one request is in work at a time; the next item is taken the cycle after
// the result is loaded into the output register, even while it waits downstream.
// Reset: configuration registers go to their defaults, the timer to zero, and
// a clearing pass zeroes the heat memory; no item is taken
// during it, configuration writes are taken at any time.
// When the receiver stalls, the result holds in the output register and a
// following write request waits at its end until the register is free.
module flash_write_wear_guard_top #(
    parameter int PAGE_COUNT = 256,
    parameter int PAGE_BYTES = 512
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [fwwg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fwwg_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // input items
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: dest_addr[31:0], write_size[49:32], buffers_secure[50], zero[55:51]
    input  logic [55:0]                        i_s_tdata,
    // tuser: kind[0]
    input  logic                               i_s_tuser,
    // result items
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata: status[2:0], granted[3], zero[7:4]
    output logic [7:0]                         o_m_tdata
);

    localparam int PW         = $clog2(PAGE_COUNT);
    localparam int PB_SH      = $clog2(PAGE_BYTES);
    localparam int SPAN_BYTES = PAGE_COUNT * PAGE_BYTES;
    localparam int HW         = fwwg_pkg::HEAT_W;
    localparam int TW         = fwwg_pkg::TIMER_W;
    localparam int AW         = fwwg_pkg::ADDR_W;
    localparam int SW         = fwwg_pkg::SIZE_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SPAN,
        S_RD,
        S_WB,
        S_DONE
    } t_state;

    // configuration registers
    logic [AW-1:0] r_window_start;
    logic [AW-1:0] r_window_end;
    logic [HW-1:0] r_wear_threshold;
    logic [TW-1:0] r_throttle_seconds;

    // control and datapath registers
    t_state             r_state;
    logic [TW-1:0]      r_throttle_left;
    logic [AW-1:0]      r_dest;
    logic [AW:0]        r_end_addr;
    logic               r_secure_ok;
    logic [AW-1:0]      r_off_first;
    logic [AW:0]        r_off_last;
    logic [PW-1:0]      r_page;
    logic [PW-1:0]      r_last;
    logic [PW-1:0]      r_clr_idx;
    logic               r_pend;
    fwwg_pkg::t_status  r_status;
    logic               r_out_valid;
    fwwg_pkg::t_status  r_out_status;

    // heat memory
    logic [HW-1:0] r_heat_mem [PAGE_COUNT];
    logic [HW-1:0] r_rd_data;

    logic              w_mem_we;
    logic [PW-1:0]     w_mem_waddr;
    logic [HW-1:0]     w_mem_wdata;
    logic [HW-1:0]     w_heat_inc;
    logic              w_hit;
    logic              w_in_acc;
    logic              w_out_free;
    logic              w_out_load;
    logic [AW:0]       w_end_limit;
    logic              w_window_bad;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_out_load = (r_state == S_DONE) && w_out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, (r_out_status == fwwg_pkg::ST_GRANTED), r_out_status};

    // window check on the captured request
    assign w_end_limit  = {1'b0, r_window_end} + (AW+1)'(fwwg_pkg::END_SLACK);
    assign w_window_bad = (r_dest < r_window_start) || (r_end_addr > w_end_limit);

    // counter update of the page under work
    assign w_heat_inc = r_rd_data + HW'(1);
    assign w_hit      = (w_heat_inc >= r_wear_threshold);

    // memory write: clearing pass or write back
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_page;
        w_mem_wdata = w_heat_inc;
        if (r_state == S_CLEAR) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr_idx;
            w_mem_wdata = '0;
        end else if (r_state == S_WB) begin
            w_mem_we = 1'b1;
        end
    end

    // heat memory, read data registered
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_heat_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= r_heat_mem[r_page];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_start     <= fwwg_pkg::RST_WINDOW_START;
            r_window_end       <= fwwg_pkg::RST_WINDOW_END;
            r_wear_threshold   <= fwwg_pkg::RST_WEAR_THRESHOLD;
            r_throttle_seconds <= fwwg_pkg::RST_THROTTLE_SECONDS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fwwg_pkg::CFG_WINDOW_START:     r_window_start     <= i_cfg_wdata[AW-1:0];
                fwwg_pkg::CFG_WINDOW_END:       r_window_end       <= i_cfg_wdata[AW-1:0];
                fwwg_pkg::CFG_WEAR_THRESHOLD:   r_wear_threshold   <= i_cfg_wdata[HW-1:0];
                fwwg_pkg::CFG_THROTTLE_SECONDS: r_throttle_seconds <= i_cfg_wdata[TW-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer with timer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr_idx       <= '0;
            r_throttle_left <= '0;
            r_pend          <= 1'b0;
            r_out_valid     <= 1'b0;
            r_page          <= '0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_clr_idx == PW'(PAGE_COUNT - 1)) begin
                        r_clr_idx <= '0;
                        r_state   <= r_pend ? S_DONE : S_IDLE;
                    end else begin
                        r_clr_idx <= r_clr_idx + PW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_s_tuser == fwwg_pkg::KIND_TICK) begin
                            if (r_throttle_left != '0) begin
                                r_throttle_left <= r_throttle_left - TW'(1);
                            end
                        end else begin
                            r_dest      <= i_s_tdata[AW-1:0];
                            r_end_addr  <= {1'b0, i_s_tdata[AW-1:0]}
                                         + (AW+1)'(i_s_tdata[AW+SW-1:AW]);
                            r_secure_ok <= i_s_tdata[AW+SW];
                            r_state     <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    // byte offsets into the window, used only once the window check passes
                    r_off_first <= r_dest - r_window_start;
                    r_off_last  <= r_end_addr - {1'b0, r_window_start};
                    if (!r_secure_ok) begin
                        r_status <= fwwg_pkg::ST_SEC_FAIL;
                        r_state  <= S_DONE;
                    end else if (w_window_bad) begin
                        r_status <= fwwg_pkg::ST_WINDOW;
                        r_state  <= S_DONE;
                    end else if (r_throttle_left != '0) begin
                        r_status <= fwwg_pkg::ST_THROTTLED;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    // page index is the offset shifted by the page size
                    if (r_off_last >= (AW+1)'(SPAN_BYTES)) begin
                        r_status <= fwwg_pkg::ST_WINDOW;
                        r_state  <= S_DONE;
                    end else begin
                        r_page  <= r_off_first[PB_SH +: PW];
                        r_last  <= r_off_last[PB_SH +: PW];
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (w_hit) begin
                        r_throttle_left <= r_throttle_seconds;
                        r_status        <= fwwg_pkg::ST_THRESHOLD;
                        r_pend          <= 1'b1;
                        r_clr_idx       <= '0;
                        r_state         <= S_CLEAR;
                    end else if (r_page == r_last) begin
                        r_status <= fwwg_pkg::ST_GRANTED;
                        r_state  <= S_DONE;
                    end else begin
                        r_page  <= r_page + PW'(1);
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_status <= r_status;
                        r_pend       <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // no item is taken while the memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready)
        else $error("input accepted during clearing pass");

    // the page walk never runs past the last page
    a_page_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_WB) |-> (r_page <= r_last))
        else $error("page walk beyond last page");

    // a threshold hit loads the throttle timer
    a_hit_loads_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB && w_hit) |=> (r_throttle_left == $past(r_throttle_seconds)))
        else $error("throttle timer not loaded on threshold hit");

    // a finished request reaches the output register once it is free
    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (o_m_tvalid && r_state == S_IDLE))
        else $error("finished request not delivered");

    // the memory is written only while clearing or writing back
    a_mem_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == S_CLEAR || r_state == S_WB))
        else $error("heat memory written outside clear or write back");

endmodule
